// ----- hdl/edw_pkg.sv -----
// shared types, constants and helpers for the event dedup window table
`timescale 1ns / 1ps
`default_nettype none

package edw_pkg;

	// table geometry
	localparam int SLOTS = 32;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// field widths
	localparam int ID_W     = 32;
	localparam int KIND_W   = 16;
	localparam int TICK_W   = 32;
	localparam int HITS_W   = 32;
	localparam int WINDOW_W = 31;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(5000);
	localparam logic [HITS_W-1:0]   HITS_MAX     = '1;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [HITS_W-1:0] hits;
		logic [TICK_W-1:0] last;
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// operations of the shared adder
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// finished result from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [HITS_W-1:0] count;
	} res_t;

	// saturating increment of a hit count
	function automatic logic [HITS_W-1:0] sat_inc(input logic [HITS_W-1:0] v);
		sat_inc = (v == HITS_MAX) ? HITS_MAX : v + HITS_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/edw_ram.sv -----
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module edw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                             clk,
	input  wire                             we,
	input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
	input  wire  [WIDTH-1:0]                wr_data,
	input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
	output logic [WIDTH-1:0]                rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- hdl/edw_alu.sv -----
// shared 32-bit adder and subtractor used for time and window arithmetic
`timescale 1ns / 1ps
`default_nettype none

module edw_alu (
	input  wire  edw_pkg::alu_op_t      op,
	input  wire  [edw_pkg::TICK_W-1:0]  a,
	input  wire  [edw_pkg::TICK_W-1:0]  b,
	output logic [edw_pkg::TICK_W-1:0]  y
);

	import edw_pkg::*;

	// add or subtract modulo 2^32
	always_comb begin
		case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/edw_ctrl.sv -----
// sequencer: scans the slot table, picks a slot and updates it
`timescale 1ns / 1ps
`default_nettype none

module edw_ctrl (
	input  wire                           clk,
	input  wire                           arst_n,
	// incoming event
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [edw_pkg::ID_W-1:0]      in_id,
	input  wire  [edw_pkg::KIND_W-1:0]    in_kind,
	input  wire  [edw_pkg::TICK_W-1:0]    in_now,
	input  wire  [edw_pkg::WINDOW_W-1:0]  window,
	// result hand-off
	input  wire                           out_free,
	output edw_pkg::res_t                 res,
	// slot memory
	output logic [edw_pkg::IDX_W-1:0]     rd_addr,
	input  wire  edw_pkg::slot_t          rd_data,
	output logic                          we,
	output logic [edw_pkg::IDX_W-1:0]     wr_addr,
	output edw_pkg::slot_t                wr_data,
	// shared adder
	output edw_pkg::alu_op_t              alu_op,
	output logic [edw_pkg::TICK_W-1:0]    alu_a,
	output logic [edw_pkg::TICK_W-1:0]    alu_b,
	input  wire  [edw_pkg::TICK_W-1:0]    alu_y
);

	import edw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT1,
		ST_HIT2,
		ST_MISS,
		ST_OUT
	} state_t;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

	state_t              state_q;
	logic [SLOTS-1:0]    valid_q;
	logic [ID_W-1:0]     id_q;
	logic [KIND_W-1:0]   kind_q;
	logic [TICK_W-1:0]   now_q;
	logic [IDX_W-1:0]    idx_q;
	logic                issuing_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [IDX_W-1:0]    old_idx_q;
	logic [TICK_W-1:0]   old_last_q;
	logic [IDX_W-1:0]    hit_idx_q;
	slot_t               hit_slot_q;
	logic [TICK_W-1:0]   sum_q;
	logic [HITS_W-1:0]   emit_q;

	slot_t               entry;
	logic                entry_valid;
	logic                entry_match;
	logic                in_window;
	logic [HITS_W-1:0]   hits_next;
	logic [IDX_W-1:0]    victim;

	// entry returned by the memory, zero when the slot was never loaded
	always_comb begin
		entry_valid = valid_q[idx_s1];
		entry       = entry_valid ? rd_data : '0;
		entry_match = entry_valid && (entry.id == id_q) && (entry.kind == kind_q);
	end

	// operand selection for the shared adder
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = entry.last;
		alu_b  = old_last_q;
		case (state_q)
			ST_HIT1: begin
				alu_op = ALU_ADD;
				alu_a  = hit_slot_q.last;
				alu_b  = TICK_W'(window);
			end
			ST_HIT2: begin
				alu_op = ALU_SUB;
				alu_a  = now_q;
				alu_b  = sum_q;
			end
			default: begin
				alu_op = ALU_SUB;
				alu_a  = entry.last;
				alu_b  = old_last_q;
			end
		endcase
	end

	// update values and memory write
	always_comb begin
		in_window = alu_y[TICK_W-1];
		hits_next = sat_inc(hit_slot_q.hits);
		victim    = free_found_q ? free_idx_q : old_idx_q;
		we        = (state_q == ST_HIT2) || (state_q == ST_MISS);
		wr_addr   = (state_q == ST_HIT2) ? hit_idx_q : victim;
		wr_data.id   = id_q;
		wr_data.kind = kind_q;
		wr_data.last = now_q;
		wr_data.hits = ((state_q == ST_HIT2) && in_window) ? hits_next : '0;
	end

	assign rd_addr   = idx_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.count = emit_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			issuing_q    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			idx_s1       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q         <= in_id;
						kind_q       <= in_kind;
						now_q        <= in_now;
						idx_q        <= '0;
						issuing_q    <= 1'b1;
						rd_vld_s1    <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_s1 <= idx_q;
					if (rd_vld_s1 && entry_match) begin
						// entry read last cycle matches: stop the scan
						hit_idx_q  <= idx_s1;
						hit_slot_q <= entry;
						issuing_q  <= 1'b0;
						rd_vld_s1  <= 1'b0;
						state_q    <= ST_HIT1;
					end else begin
						// issue one read a cycle
						rd_vld_s1 <= issuing_q;
						if (issuing_q) begin
							if (idx_q == IDX_LAST) begin
								issuing_q <= 1'b0;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
						// track first free and oldest slot
						if (rd_vld_s1) begin
							if (!entry_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_s1;
							end
							if ((idx_s1 == '0) || alu_y[TICK_W-1]) begin
								old_idx_q  <= idx_s1;
								old_last_q <= entry.last;
							end
							if (idx_s1 == IDX_LAST) begin
								state_q <= ST_MISS;
							end
						end
					end
				end
				ST_HIT1: begin
					sum_q   <= alu_y;
					state_q <= ST_HIT2;
				end
				ST_HIT2: begin
					emit_q  <= in_window ? '0 : hits_next;
					state_q <= ST_OUT;
				end
				ST_MISS: begin
					valid_q[victim] <= 1'b1;
					emit_q          <= HITS_W'(1);
					state_q         <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// valid bits only ever get set
	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & $past(valid_q)) == $past(valid_q))
		else $error("slot valid bit cleared");

	// a free slot taken on a miss was really free
	a_free_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISS && free_found_q) |-> !valid_q[free_idx_q])
		else $error("free slot already valid");

	// a new entry always reports a count of one
	a_miss_emits_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISS) |=> (state_q == ST_OUT && emit_q == HITS_W'(1)))
		else $error("miss did not report one");

	// memory is written only in the update steps
	a_write_steps: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_HIT2 || state_q == ST_MISS))
		else $error("slot write outside update step");

endmodule

`default_nettype wire

// ----- hdl/event_dedup_window_table.sv -----
// top level of the event dedup window table
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  event_id, event_kind, now_ticks
//  m_axis    out   m_axis_tvalid / m_axis_tready  emit_count
//  cfg       in    cfg_valid / cfg_ready          window_ticks
//
//  a miss scans all SLOTS entries before it writes a new one; a hit stops the scan at
//  the matching slot and then passes ST_HIT1 and ST_HIT2; the scan is paced by the slot memory,
//  read one entry per cycle during the scan
//  reset clears every slot valid bit at once and loads the window with 5000; no clearing pass
//  a new event is taken while the previous result still waits in the output register
//  a stalled output holds the sequencer only once its next result is ready
`timescale 1ns / 1ps
`default_nettype none

module event_dedup_window_table (
	input  wire         clk,
	input  wire         arst_n,
	// event input
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [79:0] s_axis_tdata,   // event_id[31:0], event_kind[47:32], now_ticks[79:48]
	// result output
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // emit_count[31:0]
	// window register write
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [30:0] cfg_data        // window_ticks[30:0]
);

	import edw_pkg::*;

	logic [WINDOW_W-1:0] window_q;
	logic                out_free;
	res_t                res;
	logic [IDX_W-1:0]    rd_addr;
	slot_t               rd_data;
	logic                we;
	logic [IDX_W-1:0]    wr_addr;
	slot_t               wr_data;
	alu_op_t             alu_op;
	logic [TICK_W-1:0]   alu_a;
	logic [TICK_W-1:0]   alu_b;
	logic [TICK_W-1:0]   alu_y;

	// window register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid) begin
			window_q <= cfg_data;
		end
	end

	// output register
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			m_axis_tdata <= res.count;
		end
	end

	// sequencer
	edw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_id    (s_axis_tdata[31:0]),
		.in_kind  (s_axis_tdata[47:32]),
		.in_now   (s_axis_tdata[79:48]),
		.window   (window_q),
		.out_free (out_free),
		.res      (res),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.we       (we),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.alu_op   (alu_op),
		.alu_a    (alu_a),
		.alu_b    (alu_b),
		.alu_y    (alu_y)
	);

	// slot memory
	edw_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared adder
	edw_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

endmodule

`default_nettype wire

// ----- tb/tb_event_dedup_window_table.sv -----
// self-checking testbench for the event dedup window table
`timescale 1ns / 1ps

module tb_event_dedup_window_table;

	import edw_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE       = SLOTS + 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int POOL_MAX     = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int N_ROWS       = 19;

	typedef enum logic {
		ROW_EVENT,
		ROW_WINDOW
	} row_op_t;

	// one directed row: an event, or a window write carried in the window field
	typedef struct packed {
		row_op_t             op;
		logic [ID_W-1:0]     id;
		logic [KIND_W-1:0]   kind;
		logic [TICK_W-1:0]   now;
		logic [WINDOW_W-1:0] window;
		logic                known;
		logic [HITS_W-1:0]   emit;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		// reset window of 5000: new entry, suppress, last tick inside, first tick past
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'd0,          31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'd100,        31'd0, 1'b1, 32'd0},
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'd5099,       31'd0, 1'b1, 32'd0},
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'd10099,      31'd0, 1'b1, 32'd3},
		// all-ones key, then a hit after the timestamp wraps
		'{ROW_EVENT,  32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,  31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'hFFFF_FFFF, 16'hFFFF, 32'd16,         31'd0, 1'b1, 32'd0},
		// same id other kind, same kind other id
		'{ROW_EVENT,  32'hFFFF_FFFF, 16'h0000, 32'd20,         31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'h0000_0000, 16'hFFFF, 32'd20,         31'd0, 1'b1, 32'd1},
		// half the tick range ahead is past, one tick behind is inside
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'h8000_2773,  31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'h0000_0000, 16'h0000, 32'h8000_2772,  31'd0, 1'b1, 32'd0},
		// zero window: equal time is past, an earlier time is inside
		'{ROW_WINDOW, 32'h0,         16'h0,    32'd0,          31'd0, 1'b0, 32'd0},
		'{ROW_EVENT,  32'd5,         16'd5,    32'd1000,       31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'd5,         16'd5,    32'd1000,       31'd0, 1'b1, 32'd1},
		'{ROW_EVENT,  32'd5,         16'd5,    32'd999,        31'd0, 1'b1, 32'd0},
		// widest window, both sides of its edge with the sum wrapping
		'{ROW_WINDOW, 32'h0,         16'h0,    32'd0,   31'h7FFF_FFFF, 1'b0, 32'd0},
		'{ROW_EVENT,  32'd5,         16'd5,    32'h8000_03E5,  31'd0, 1'b1, 32'd0},
		'{ROW_EVENT,  32'd5,         16'd5,    32'h0000_03E4,  31'd0, 1'b1, 32'd3},
		// mixed bit patterns, left to the predictor
		'{ROW_EVENT,  32'hA5A5_5A5A, 16'h5A5A, 32'h1234_5678,  31'd0, 1'b0, 32'd0},
		'{ROW_EVENT,  32'hA5A5_5A5A, 16'h5A5A, 32'h1234_5678,  31'd0, 1'b0, 32'd0}
	};

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [79:0]         s_axis_tdata;   // event_id[31:0], event_kind[47:32], now_ticks[79:48]
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [31:0]         m_axis_tdata;   // emit_count[31:0]
	logic                cfg_valid;
	logic                cfg_ready;
	logic [WINDOW_W-1:0] cfg_data;       // window_ticks[30:0]

	// predicted table contents and window
	bit                  tbl_used [SLOTS];
	logic [ID_W-1:0]     tbl_id   [SLOTS];
	logic [KIND_W-1:0]   tbl_kind [SLOTS];
	logic [TICK_W-1:0]   tbl_last [SLOTS];
	logic [HITS_W-1:0]   tbl_hits [SLOTS];
	logic [WINDOW_W-1:0] window_model;

	logic [HITS_W-1:0]   pending_counts [$];

	int errors;
	int cycles;
	int events_sent;
	int window_writes;
	int counts_seen;
	int n_suppressed;
	int n_reported;
	int n_new;
	int n_evicted;
	int hold_ask;
	bit quiet;

	event_dedup_window_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d counts still pending", $time, cycles,
			pending_counts.size());
		$display("event_dedup_window_table test failed");
		$finish;
	end

	// true when tick a lies strictly before tick b, modulo 2^32
	function automatic bit tick_earlier(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
		logic [TICK_W-1:0] diff;
		diff = a - b;
		return diff[TICK_W-1];
	endfunction

	// look up the event in the predicted table, update it and return the emit count
	function automatic logic [HITS_W-1:0] coalesce_event(input logic [ID_W-1:0] id,
			input logic [KIND_W-1:0] kind, input logic [TICK_W-1:0] now);
		int i;
		int hit;
		int spare;
		int oldest;
		int s;
		logic [HITS_W-1:0] emit;
		hit = -1;
		spare = -1;
		oldest = 0;
		for (i = 0; i < SLOTS && hit < 0; i++) begin
			if (tbl_used[i] && tbl_id[i] == id && tbl_kind[i] == kind) begin
				hit = i;
			end else begin
				if (!tbl_used[i] && spare < 0)
					spare = i;
				if (tick_earlier(tbl_last[i], tbl_last[oldest]))
					oldest = i;
			end
		end
		if (hit >= 0) begin
			if (tick_earlier(now, tbl_last[hit] + {1'b0, window_model})) begin
				if (tbl_hits[hit] != HITS_MAX)
					tbl_hits[hit] = tbl_hits[hit] + HITS_W'(1);
				emit = '0;
				n_suppressed++;
			end else begin
				emit = (tbl_hits[hit] == HITS_MAX) ? HITS_MAX : tbl_hits[hit] + HITS_W'(1);
				tbl_hits[hit] = '0;
				n_reported++;
			end
			tbl_last[hit] = now;
		end else begin
			s = (spare >= 0) ? spare : oldest;
			if (spare < 0)
				n_evicted++;
			tbl_used[s] = 1'b1;
			tbl_id[s] = id;
			tbl_kind[s] = kind;
			tbl_last[s] = now;
			tbl_hits[s] = '0;
			emit = 1;
			n_new++;
		end
		return emit;
	endfunction

	// idle length for either side: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// tick advance for a key, spread around the window edge
	function automatic logic [TICK_W-1:0] next_step(input logic [WINDOW_W-1:0] w);
		logic [TICK_W-1:0] span;
		span = {1'b0, w};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, (span > 1000) ? span / 4 : span);
			4: return '0;
			5: return span - 32'd1 + 32'($urandom_range(0, 2));
			6: return span + 32'($urandom_range(0, 1000));
			7: return 32'd0 - 32'($urandom_range(1, 50));
			8: return $urandom;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// window for each random phase, extremes among them
	function automatic logic [WINDOW_W-1:0] phase_window(input int p);
		case (p)
			0: return WINDOW_RESET;
			1: return 31'd1;
			2: return 31'h7FFF_FFFF;
			3: return 31'd0;
			4: return WINDOW_W'($urandom_range(2, 100));
			5: return WINDOW_W'($urandom_range(100, 100000));
			6: return WINDOW_W'($urandom);
			default: return WINDOW_RESET;
		endcase
	endfunction

	// offer one event; returns at the edge where the transaction is taken
	task automatic send_event(input logic [ID_W-1:0] id, input logic [KIND_W-1:0] kind,
			input logic [TICK_W-1:0] now, input bit known, input logic [HITS_W-1:0] emit);
		int gap;
		logic [HITS_W-1:0] predicted;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {now, kind, id};
		do @(posedge clk); while (!s_axis_tready);
		predicted = coalesce_event(id, kind, now);
		pending_counts.push_back(known ? emit : predicted);
		events_sent++;
	endtask

	// stop offering and wait until every count has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// window register write, only while the block is idle
	task automatic write_window(input logic [WINDOW_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_model = value;
		window_writes++;
	endtask

	// result side: random stalls plus the long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = quiet ? 0 : pick_gap();
			end
		end
	end

	// compare each result transaction with the oldest pending count
	always @(posedge clk) begin : count_check
		logic [HITS_W-1:0] want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (pending_counts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual emit_count %0d",
					$time, m_axis_tdata);
			end else begin
				want = pending_counts.pop_front();
				counts_seen++;
				if (m_axis_tdata !== want) begin
					errors++;
					$display("%0t: emit_count mismatch, expected %0d, actual %0d",
						$time, want, m_axis_tdata);
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int i;
		int p;
		int n;
		int j;
		int pool_n;
		logic [ID_W-1:0]     pool_id   [POOL_MAX];
		logic [KIND_W-1:0]   pool_kind [POOL_MAX];
		logic [TICK_W-1:0]   key_time  [POOL_MAX];
		logic [TICK_W-1:0]   base;
		logic [WINDOW_W-1:0] w;

		errors = 0;
		events_sent = 0;
		window_writes = 0;
		counts_seen = 0;
		n_suppressed = 0;
		n_reported = 0;
		n_new = 0;
		n_evicted = 0;
		hold_ask = 0;
		quiet = 1'b0;
		window_model = WINDOW_RESET;
		for (i = 0; i < SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_kind[i] = '0;
			tbl_last[i] = '0;
			tbl_hits[i] = '0;
		end

		// reset, held low and then released
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (i = 0; i < N_ROWS; i++) begin
			if (DIRECTED_ROWS[i].op == ROW_WINDOW) begin
				wait_drained();
				write_window(DIRECTED_ROWS[i].window);
			end else begin
				send_event(DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].now,
					DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].emit);
			end
		end

		// random phases, each with its own window and pool of recurring keys
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			w = phase_window(p);
			write_window(w);
			quiet = (p == 4);
			pool_n = (p % 2 == 0) ? $urandom_range(33, POOL_MAX) : $urandom_range(6, 24);
			base = $urandom;
			for (j = 0; j < pool_n; j++) begin
				pool_id[j] = (j > 0 && $urandom_range(0, 3) == 0) ? pool_id[j-1] : $urandom;
				pool_kind[j] = (j > 0 && $urandom_range(0, 3) == 0) ? pool_kind[j-1]
					: KIND_W'($urandom);
				key_time[j] = base;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// receiver holds off long enough for the input to back up
				if (p == 2 && n == 100)
					hold_ask = HOLD_CYCLES;
				// sender pause until the block has drained
				if (p == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
				if ($urandom_range(0, 9) == 0) begin
					send_event($urandom, KIND_W'($urandom), $urandom, 1'b0, '0);
				end else begin
					j = $urandom_range(0, pool_n - 1);
					key_time[j] = key_time[j] + next_step(w);
					send_event(pool_id[j], pool_kind[j], key_time[j], 1'b0, '0);
				end
			end
			quiet = 1'b0;
		end

		wait_drained();

		$display("covered %0d events over %0d window settings, %0d counts checked",
			events_sent, window_writes, counts_seen);
		$display("suppressed %0d, repeats reported %0d, new entries %0d, evictions %0d",
			n_suppressed, n_reported, n_new, n_evicted);
		if (errors == 0)
			$display("event_dedup_window_table test passed");
		else
			$display("event_dedup_window_table test failed");
		$finish;
	end

endmodule

// ----- event_dedup_window_table.f -----
hdl/edw_pkg.sv
hdl/edw_ram.sv
hdl/edw_alu.sv
hdl/edw_ctrl.sv
hdl/event_dedup_window_table.sv
tb/tb_event_dedup_window_table.sv
